// File: hdl/ttoe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ttoe_pkg;

    localparam int MAX_COLUMNS = 256;
    localparam int MAX_ROWS    = 128;

    // Result kinds
    localparam logic [1:0] KIND_PUT    = 2'd0;
    localparam logic [1:0] KIND_SCROLL = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;
    localparam logic [1:0] KIND_REPORT = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] CFG_COLUMNS  = 3'd0;
    localparam logic [2:0] CFG_ROWS     = 3'd1;
    localparam logic [2:0] CFG_POST     = 3'd2;
    localparam logic [2:0] CFG_UPPER    = 3'd3;
    localparam logic [2:0] CFG_NL_CR    = 3'd4;
    localparam logic [2:0] CFG_CR_NL    = 3'd5;
    localparam logic [2:0] CFG_DROP_CR  = 3'd6;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UB    = 8'h42;
    localparam logic [7:0] CH_UC    = 8'h43;
    localparam logic [7:0] CH_UD    = 8'h44;
    localparam logic [7:0] CH_UH    = 8'h48;
    localparam logic [7:0] CH_UJ    = 8'h4A;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CASE_GAP = 8'h20;

    typedef enum logic [3:0] {
        S_IDLE, S_CELLS, S_CLAMP, S_DIV, S_DIVEND, S_XLATE, S_RAW,
        S_PARSE1, S_PARSE2, S_TAB, S_CHK, S_REPORT
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_CELLS, OP_DIV_INIT, OP_DIV_STEP, OP_DIV_END, OP_XLATE,
        OP_NEXT_RAW, OP_EXEC, OP_PUT, OP_CLEAR_SCR, OP_TAB_STEP, OP_SCROLL,
        OP_REPORT, OP_PARSE_INIT, OP_PARSE_STEP, OP_P1_SAVE, OP_ESC_APPLY
    } dp_op_t;

    typedef enum logic [3:0] {
        RC_NOP, RC_NL, RC_CR, RC_BS, RC_TAB, RC_FF, RC_ESCAPE, RC_PRINT,
        RC_ESC_MOVE, RC_ESC_H, RC_ESC_J, RC_ESC_SIMPLE
    } raw_class_t;

    typedef enum logic {
        PH_SKIP, PH_DIGIT
    } pphase_t;

    typedef struct packed {
        logic   load_byte;
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic       geom_valid;
        logic       drop;
        raw_class_t raw_class;
        logic       pending;
        logic       parse_end;
        logic       div_last;
        logic       tab_emit;
        logic       tab_last;
        logic       row_over;
        logic       out_free;
    } dp_status_t;

endpackage
`default_nettype wire

// File: hdl/text_terminal_output_engine_core.sv
`timescale 1ns / 1ps
`default_nettype none
// A printable byte yields a put result and then a cursor report once the byte is accepted;
// a tab pads with spaces to the next multiple-of-8 column (up to 8 padding cells), an escape
// parameter is parsed one buffered byte per step, and each scroll emits its own result;
// a wait on m_tready stalls the sequencer. Only one byte is in flight at a time.
// After a columns or rows write the next byte first runs a 15-step divider.
// Reset (aresetn low, synchronous): cursor at cell 0, escape buffer cleared, defaults loaded.
module text_terminal_output_engine_core import ttoe_pkg::*; #(
    parameter int ESC_BUF_SIZE = 10
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [8:0]  cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] out_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [6:0] cell_row, [14:7] cell_col, [22:15] glyph,
                                        // [37:23] cursor_pos, [39:38] zero
    output logic [1:0]       m_tuser,   // [1:0] kind
    output logic             m_tlast
);

    dp_cmd_t    cmd;
    dp_status_t st;

    ttoe_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    ttoe_dp #(
        .ESC_BUF_SIZE (ESC_BUF_SIZE)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .st        (st)
    );

endmodule
`default_nettype wire

// File: hdl/ttoe_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module ttoe_ctrl import ttoe_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire dp_status_t st,
    output dp_cmd_t         cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = st.geom_valid ? S_XLATE : S_CELLS;
                end
            end
            S_CELLS:  state_next = S_CLAMP;
            S_CLAMP:  state_next = S_DIV;
            S_DIV: begin
                if (st.div_last) begin
                    state_next = S_DIVEND;
                end
            end
            S_DIVEND: state_next = S_XLATE;
            S_XLATE:  state_next = st.drop ? S_IDLE : S_RAW;
            S_RAW: begin
                case (st.raw_class) inside
                    RC_PRINT, RC_FF, RC_ESC_J: begin
                        if (st.out_free) begin
                            state_next = S_CHK;
                        end
                    end
                    RC_TAB:              state_next = S_TAB;
                    RC_ESC_MOVE, RC_ESC_H: state_next = S_PARSE1;
                    default:             state_next = S_CHK;
                endcase
            end
            S_PARSE1: begin
                if (st.parse_end) begin
                    state_next = (st.raw_class == RC_ESC_H) ? S_PARSE2 : S_CHK;
                end
            end
            S_PARSE2: begin
                if (st.parse_end) begin
                    state_next = S_CHK;
                end
            end
            S_TAB: begin
                if ((!st.tab_emit || st.out_free) && st.tab_last) begin
                    state_next = S_CHK;
                end
            end
            S_CHK: begin
                if (!st.row_over) begin
                    state_next = st.pending ? S_RAW : S_REPORT;
                end
            end
            S_REPORT: begin
                if (st.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Commands to the datapath
    always_comb begin
        s_tready      = 1'b0;
        cmd.load_byte = 1'b0;
        cmd.op        = OP_NONE;
        unique case (state_reg)
            S_IDLE: begin
                s_tready      = 1'b1;
                cmd.load_byte = s_tvalid;
            end
            S_CELLS:  cmd.op = OP_CELLS;
            S_CLAMP:  cmd.op = OP_DIV_INIT;
            S_DIV:    cmd.op = OP_DIV_STEP;
            S_DIVEND: cmd.op = OP_DIV_END;
            S_XLATE:  cmd.op = OP_XLATE;
            S_RAW: begin
                case (st.raw_class) inside
                    RC_PRINT: begin
                        if (st.out_free) begin
                            cmd.op = OP_PUT;
                        end
                    end
                    RC_FF, RC_ESC_J: begin
                        if (st.out_free) begin
                            cmd.op = OP_CLEAR_SCR;
                        end
                    end
                    RC_ESC_MOVE, RC_ESC_H: cmd.op = OP_PARSE_INIT;
                    default:               cmd.op = OP_EXEC;
                endcase
            end
            S_PARSE1: begin
                if (!st.parse_end) begin
                    cmd.op = OP_PARSE_STEP;
                end else if (st.raw_class == RC_ESC_H) begin
                    cmd.op = OP_P1_SAVE;
                end else begin
                    cmd.op = OP_ESC_APPLY;
                end
            end
            S_PARSE2: cmd.op = st.parse_end ? OP_ESC_APPLY : OP_PARSE_STEP;
            S_TAB: begin
                if (!st.tab_emit || st.out_free) begin
                    cmd.op = OP_TAB_STEP;
                end
            end
            S_CHK: begin
                if (st.row_over) begin
                    if (st.out_free) begin
                        cmd.op = OP_SCROLL;
                    end
                end else if (st.pending) begin
                    cmd.op = OP_NEXT_RAW;
                end
            end
            S_REPORT: begin
                if (st.out_free) begin
                    cmd.op = OP_REPORT;
                end
            end
            default: cmd.op = OP_NONE;
        endcase
    end

endmodule
`default_nettype wire

// File: hdl/ttoe_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module ttoe_dp import ttoe_pkg::*; #(
    parameter int ESC_BUF_SIZE = 10
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [8:0]  cfg_wdata,
    input  wire logic [7:0]  s_tdata,
    input  wire logic        m_tready,
    output logic             m_tvalid,
    output logic [39:0]      m_tdata,
    output logic [1:0]       m_tuser,
    output logic             m_tlast,
    input  wire dp_cmd_t     cmd,
    output dp_status_t       st
);

    localparam int IDX_W = $clog2(ESC_BUF_SIZE);
    localparam logic [IDX_W-1:0] IDX_END = IDX_W'(ESC_BUF_SIZE - 1);

    // Configuration
    logic [8:0] columns_reg;
    logic [7:0] rows_reg;
    logic       post_reg, upper_reg, nl_cr_reg, cr_nl_reg, drop_cr_reg;

    // Cursor and item state
    logic [7:0]  row_reg, col_reg;
    logic [14:0] pos_reg;
    logic        geom_valid_reg;
    logic [7:0]  byte_reg, raw_reg;
    logic        pend_reg;

    // Escape sequence buffer
    logic             esc_act_reg;
    logic [7:0]       esc_buf_reg [ESC_BUF_SIZE];
    logic [IDX_W-1:0] esc_cnt_reg;

    // Divider, tab counter and parameter parser
    logic [15:0]      cells_reg;
    logic [14:0]      dq_reg;
    logic [8:0]       rem_reg;
    logic [3:0]       dcnt_reg;
    logic [3:0]       tab_cnt_reg;
    logic [IDX_W-1:0] pidx_reg;
    pphase_t          phase_reg;
    logic             neg_reg;
    logic [15:0]      pval_reg, p1_reg;

    // Output register
    logic        m_tvalid_reg, last_reg;
    logic [1:0]  kind_reg;
    logic [6:0]  orow_reg;
    logic [7:0]  ocol_reg, glyph_reg;
    logic [14:0] opos_reg;

    // Effective geometry
    logic [8:0] eff_cols;
    logic [7:0] eff_rows, rows_m1, cols_m1;

    always_comb begin
        if (columns_reg < 9'd8) begin
            eff_cols = 9'd8;
        end else if (columns_reg > 9'(MAX_COLUMNS)) begin
            eff_cols = 9'(MAX_COLUMNS);
        end else begin
            eff_cols = columns_reg;
        end
        if (rows_reg == 8'd0) begin
            eff_rows = 8'd1;
        end else if (rows_reg > 8'(MAX_ROWS)) begin
            eff_rows = 8'(MAX_ROWS);
        end else begin
            eff_rows = rows_reg;
        end
        rows_m1 = eff_rows - 8'd1;
        cols_m1 = 8'(eff_cols - 9'd1);
    end

    // Output translation
    logic [7:0] xl_byte;
    logic       xl_lf, xl_cr, xl_two, xl_cr_nl;

    always_comb begin
        xl_byte = byte_reg;
        if (post_reg && upper_reg && byte_reg >= CH_LA && byte_reg <= CH_LZ) begin
            xl_byte = byte_reg - CASE_GAP;
        end
        xl_lf    = (xl_byte == CH_LF);
        xl_cr    = (xl_byte == CH_CR);
        xl_two   = post_reg && xl_lf && nl_cr_reg;
        xl_cr_nl = post_reg && xl_cr && cr_nl_reg;
    end

    // Classification of the raw byte
    logic       raw_letter;
    logic       semi_found;
    logic [IDX_W-1:0] semi_idx;
    raw_class_t raw_class;

    always_comb begin
        logic stop;
        stop       = 1'b0;
        semi_found = 1'b0;
        semi_idx   = '0;
        for (int i = 1; i < ESC_BUF_SIZE - 1; i++) begin
            if (!stop) begin
                if (esc_buf_reg[i] == CH_SEMI) begin
                    semi_found = 1'b1;
                    semi_idx   = IDX_W'(i);
                    stop       = 1'b1;
                end else if (esc_buf_reg[i] == CH_NUL) begin
                    stop = 1'b1;
                end
            end
        end
    end

    always_comb begin
        raw_letter = (raw_reg >= CH_LA && raw_reg <= CH_LZ) ||
                     (raw_reg >= CH_UA && raw_reg <= CH_UZ);
        if (esc_act_reg) begin
            unique case (raw_reg) inside
                CH_UA, CH_UB, CH_UC, CH_UD: raw_class = RC_ESC_MOVE;
                CH_UH:   raw_class = semi_found ? RC_ESC_H : RC_ESC_SIMPLE;
                CH_UJ:   raw_class = RC_ESC_J;
                default: raw_class = RC_ESC_SIMPLE;
            endcase
        end else begin
            unique case (raw_reg) inside
                CH_LF:            raw_class = RC_NL;
                CH_CR:            raw_class = RC_CR;
                CH_BS:            raw_class = RC_BS;
                CH_TAB:           raw_class = RC_TAB;
                CH_FF:            raw_class = RC_FF;
                CH_ESC:           raw_class = RC_ESCAPE;
                [CH_SPACE:CH_TILDE]: raw_class = RC_PRINT;
                default:          raw_class = RC_NOP;
            endcase
        end
    end

    // Parameter parser, one buffered byte per step
    logic [7:0]  pb;
    logic        pb_digit, pb_blank, pb_sign, at_end, parse_end;
    logic [19:0] acc_wide;
    logic [15:0] acc_sat, param_val;

    always_comb begin
        pb       = esc_buf_reg[pidx_reg];
        pb_digit = (pb >= CH_ZERO) && (pb <= CH_NINE);
        pb_blank = (pb == CH_SPACE) || (pb >= CH_TAB && pb <= CH_CR);
        pb_sign  = (pb == CH_PLUS) || (pb == CH_MINUS);
        at_end   = (pidx_reg == IDX_END);
        if (phase_reg == PH_SKIP) begin
            parse_end = at_end || !(pb_blank || pb_sign || pb_digit);
        end else begin
            parse_end = at_end || !pb_digit;
        end
        acc_wide  = 20'({pval_reg, 3'b000}) + 20'({pval_reg, 1'b0}) + 20'(pb - CH_ZERO);
        acc_sat   = (acc_wide > 20'd65535) ? 16'hFFFF : acc_wide[15:0];
        param_val = neg_reg ? 16'd0 : pval_reg;
    end

    // Cursor moves of an escape sequence
    logic [7:0]  row_new, col_new;
    logic [16:0] sum_r, sum_c;
    logic [15:0] p1_m1, pv_m1;

    always_comb begin
        row_new = row_reg;
        col_new = col_reg;
        sum_r   = {9'd0, row_reg} + {1'b0, param_val};
        sum_c   = {9'd0, col_reg} + {1'b0, param_val};
        p1_m1   = p1_reg - 16'd1;
        pv_m1   = param_val - 16'd1;
        case (raw_reg)
            CH_UA: row_new = (param_val >= {8'd0, row_reg}) ? 8'd0
                                                            : row_reg - param_val[7:0];
            CH_UB: row_new = (sum_r > {9'd0, rows_m1}) ? rows_m1 : sum_r[7:0];
            CH_UC: col_new = (sum_c > {9'd0, cols_m1}) ? cols_m1 : sum_c[7:0];
            CH_UD: col_new = (param_val >= {8'd0, col_reg}) ? 8'd0
                                                            : col_reg - param_val[7:0];
            CH_UH: begin
                if (p1_reg == 16'd0) begin
                    row_new = 8'd0;
                end else begin
                    row_new = (p1_m1 > {8'd0, rows_m1}) ? rows_m1 : p1_m1[7:0];
                end
                if (param_val == 16'd0) begin
                    col_new = 8'd0;
                end else begin
                    col_new = (pv_m1 > {8'd0, cols_m1}) ? cols_m1 : pv_m1[7:0];
                end
            end
            default: ;
        endcase
    end

    // Misc datapath terms
    logic        col_wrap, tab_emit, out_free, div_ge;
    logic [9:0]  div_trial;
    logic [8:0]  rem_n;
    logic [15:0] cells_prod;
    logic [14:0] rep_pos, clamped;

    always_comb begin
        col_wrap   = ({1'b0, col_reg} + 9'd1) == eff_cols;
        tab_emit   = row_reg < eff_rows;
        out_free   = !m_tvalid_reg || m_tready;
        div_trial  = {rem_reg, dq_reg[14]};
        div_ge     = div_trial >= {1'b0, eff_cols};
        rem_n      = div_ge ? 9'(div_trial - {1'b0, eff_cols}) : div_trial[8:0];
        cells_prod = 16'(eff_rows * eff_cols);
        rep_pos    = 15'(row_reg * eff_cols + {9'd0, col_reg});
        clamped    = ({1'b0, pos_reg} >= cells_reg) ? 15'(cells_reg - 16'd1) : pos_reg;
    end

    // Result selection
    logic        em_valid, em_last;
    logic [1:0]  em_kind;
    logic [7:0]  em_glyph;

    always_comb begin
        em_valid = 1'b0;
        em_kind  = KIND_PUT;
        em_glyph = raw_reg;
        em_last  = 1'b0;
        unique case (cmd.op)
            OP_PUT:       em_valid = 1'b1;
            OP_TAB_STEP: begin
                em_valid = tab_emit;
                em_glyph = CH_SPACE;
            end
            OP_CLEAR_SCR: begin
                em_valid = 1'b1;
                em_kind  = KIND_CLEAR;
            end
            OP_SCROLL: begin
                em_valid = 1'b1;
                em_kind  = KIND_SCROLL;
            end
            OP_REPORT: begin
                em_valid = 1'b1;
                em_kind  = KIND_REPORT;
                em_last  = 1'b1;
            end
            default: ;
        endcase
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            columns_reg <= 9'd80;
            rows_reg    <= 8'd25;
            post_reg    <= 1'b1;
            upper_reg   <= 1'b0;
            nl_cr_reg   <= 1'b1;
            cr_nl_reg   <= 1'b0;
            drop_cr_reg <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_COLUMNS: columns_reg <= cfg_wdata;
                CFG_ROWS:    rows_reg    <= cfg_wdata[7:0];
                CFG_POST:    post_reg    <= cfg_wdata[0];
                CFG_UPPER:   upper_reg   <= cfg_wdata[0];
                CFG_NL_CR:   nl_cr_reg   <= cfg_wdata[0];
                CFG_CR_NL:   cr_nl_reg   <= cfg_wdata[0];
                CFG_DROP_CR: drop_cr_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Cursor, escape and sequencing state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg        <= '0;
            col_reg        <= '0;
            pos_reg        <= '0;
            geom_valid_reg <= 1'b1;
            pend_reg       <= 1'b0;
            esc_act_reg    <= 1'b0;
            esc_cnt_reg    <= '0;
            for (int i = 0; i < ESC_BUF_SIZE; i++) begin
                esc_buf_reg[i] <= CH_NUL;
            end
        end else begin
            if (cfg_we && (cfg_addr == CFG_COLUMNS || cfg_addr == CFG_ROWS)) begin
                geom_valid_reg <= 1'b0;
            end
            if (cmd.load_byte) begin
                byte_reg <= s_tdata;
            end
            unique case (cmd.op)
                OP_CELLS: cells_reg <= cells_prod;
                OP_DIV_INIT: begin
                    pos_reg  <= clamped;
                    dq_reg   <= clamped;
                    rem_reg  <= '0;
                    dcnt_reg <= '0;
                end
                OP_DIV_STEP: begin
                    dq_reg   <= {dq_reg[13:0], div_ge};
                    rem_reg  <= rem_n;
                    dcnt_reg <= dcnt_reg + 4'd1;
                end
                OP_DIV_END: begin
                    row_reg        <= dq_reg[7:0];
                    col_reg        <= rem_reg[7:0];
                    geom_valid_reg <= 1'b1;
                end
                OP_XLATE: begin
                    pend_reg <= xl_two;
                    if (xl_two) begin
                        raw_reg <= CH_CR;
                    end else if (xl_cr_nl) begin
                        raw_reg <= CH_LF;
                    end else begin
                        raw_reg <= xl_byte;
                    end
                end
                OP_NEXT_RAW: begin
                    raw_reg  <= CH_LF;
                    pend_reg <= 1'b0;
                end
                OP_EXEC: begin
                    unique case (raw_class)
                        RC_NL: row_reg <= row_reg + 8'd1;
                        RC_CR: col_reg <= 8'd0;
                        RC_BS: begin
                            if (col_reg != 8'd0) begin
                                col_reg <= col_reg - 8'd1;
                            end else if (row_reg != 8'd0) begin
                                row_reg <= row_reg - 8'd1;
                                col_reg <= cols_m1;
                            end
                        end
                        RC_TAB: tab_cnt_reg <= 4'd8 - {1'b0, col_reg[2:0]};
                        RC_ESCAPE: begin
                            esc_act_reg <= 1'b1;
                            esc_cnt_reg <= '0;
                            for (int i = 0; i < ESC_BUF_SIZE; i++) begin
                                esc_buf_reg[i] <= CH_NUL;
                            end
                        end
                        RC_ESC_SIMPLE: begin
                            if (raw_letter) begin
                                esc_act_reg <= 1'b0;
                                esc_cnt_reg <= '0;
                                for (int i = 0; i < ESC_BUF_SIZE; i++) begin
                                    esc_buf_reg[i] <= CH_NUL;
                                end
                            end else if (esc_cnt_reg < IDX_END) begin
                                esc_buf_reg[esc_cnt_reg] <= raw_reg;
                                esc_cnt_reg              <= esc_cnt_reg + 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
                OP_PUT: begin
                    if (col_wrap) begin
                        col_reg <= 8'd0;
                        row_reg <= row_reg + 8'd1;
                    end else begin
                        col_reg <= col_reg + 8'd1;
                    end
                end
                OP_TAB_STEP: begin
                    tab_cnt_reg <= tab_cnt_reg - 4'd1;
                    if (col_wrap) begin
                        col_reg <= 8'd0;
                        row_reg <= row_reg + 8'd1;
                    end else begin
                        col_reg <= col_reg + 8'd1;
                    end
                end
                OP_CLEAR_SCR: begin
                    if (esc_act_reg) begin
                        esc_act_reg <= 1'b0;
                        esc_cnt_reg <= '0;
                        for (int i = 0; i < ESC_BUF_SIZE; i++) begin
                            esc_buf_reg[i] <= CH_NUL;
                        end
                    end
                end
                OP_SCROLL: row_reg <= row_reg - 8'd1;
                OP_REPORT: pos_reg <= rep_pos;
                OP_PARSE_INIT, OP_P1_SAVE: begin
                    pidx_reg  <= (cmd.op == OP_P1_SAVE) ? semi_idx + 1'b1 : IDX_W'(1);
                    phase_reg <= PH_SKIP;
                    neg_reg   <= 1'b0;
                    pval_reg  <= '0;
                    if (cmd.op == OP_P1_SAVE) begin
                        p1_reg <= param_val;
                    end
                end
                OP_PARSE_STEP: begin
                    if (phase_reg == PH_SKIP && pb_blank) begin
                        pidx_reg <= pidx_reg + 1'b1;
                    end else if (phase_reg == PH_SKIP && pb_sign) begin
                        pidx_reg  <= pidx_reg + 1'b1;
                        neg_reg   <= (pb == CH_MINUS);
                        phase_reg <= PH_DIGIT;
                    end else if (pb_digit) begin
                        pidx_reg  <= pidx_reg + 1'b1;
                        pval_reg  <= acc_sat;
                        phase_reg <= PH_DIGIT;
                    end
                end
                OP_ESC_APPLY: begin
                    row_reg     <= row_new;
                    col_reg     <= col_new;
                    esc_act_reg <= 1'b0;
                    esc_cnt_reg <= '0;
                    for (int i = 0; i < ESC_BUF_SIZE; i++) begin
                        esc_buf_reg[i] <= CH_NUL;
                    end
                end
                default: ;
            endcase
        end
    end

    // Output register: one transaction held until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (em_valid) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (em_valid) begin
            kind_reg  <= em_kind;
            last_reg  <= em_last;
            orow_reg  <= (em_kind == KIND_PUT) ? row_reg[6:0] : 7'd0;
            ocol_reg  <= (em_kind == KIND_PUT) ? col_reg : 8'd0;
            glyph_reg <= (em_kind == KIND_PUT) ? em_glyph : 8'd0;
            opos_reg  <= (em_kind == KIND_REPORT) ? rep_pos : 15'd0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, opos_reg, glyph_reg, ocol_reg, orow_reg};
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

    // Status to the controller
    always_comb begin
        st.geom_valid = geom_valid_reg;
        st.drop       = post_reg && xl_cr && !cr_nl_reg && drop_cr_reg &&
                        (col_reg == 8'd0);
        st.raw_class  = raw_class;
        st.pending    = pend_reg;
        st.parse_end  = parse_end;
        st.div_last   = (dcnt_reg == 4'd14);
        st.tab_emit   = tab_emit;
        st.tab_last   = (tab_cnt_reg == 4'd1);
        st.row_over   = (row_reg >= eff_rows);
        st.out_free   = out_free;
    end

endmodule
`default_nettype wire
